// ----- rtl/ldr_pkg.sv -----
// Shared types, register codes and arithmetic constants of the lamp current duty regulator.
`default_nettype none

package ldr_pkg;

  // Field widths.
  localparam int MV_W     = 12;
  localparam int GAIN_W   = 16;
  localparam int DUTY_W   = 10;
  localparam int DB_W     = 16;
  localparam int PERIOD_W = 2;
  localparam int SUM_W    = 16;

  // Averaging block length and the counter that walks through it.
  localparam int AVG_LEN = 51;
  localparam int CNT_W   = (AVG_LEN > 2) ? $clog2(AVG_LEN) : 1;

  // Exact floor division of a SUM_W-bit sum by AVG_LEN: (x * AVG_MUL) >> AVG_SHIFT.
  localparam int AVG_SHIFT = SUM_W + $clog2(AVG_LEN);
  localparam int AVG_MUL_W = SUM_W + 1;
  localparam longint unsigned AVG_MUL =
    ((64'd1 << AVG_SHIFT) + AVG_LEN - 1) / AVG_LEN;

  // Target current: x / 1000 is done as (x >> 3) / 125 with a reciprocal and one correction.
  localparam int PROD_W    = MV_W + GAIN_W;          // set_mv * gain
  localparam int TY_W      = PROD_W - 3;             // product divided by 8
  localparam int T_SHIFT   = 32;
  localparam int T_MUL_W   = 26;
  localparam longint unsigned T_MUL = (64'd1 << T_SHIFT) / 125;
  localparam int TGT_W     = 19;                     // up to 268365 mA
  localparam int T_REM_W   = TY_W + 1;

  // Measured current: (mv - 600) * 1000 / 60 = (mv - 600) * 50 / 3.
  localparam int FB_OFFSET = 600;
  localparam int MNUM_W    = 18;                     // (mv - 600) * 50
  localparam int M_SHIFT   = 20;
  localparam int M_MUL_W   = 19;
  localparam longint unsigned M_MUL = (64'd1 << M_SHIFT) / 3;
  localparam int MEAS_W    = 17;

  // Configuration port.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Small queue between the classifying front and the duty back end.
  localparam int Q_DEPTH = 2;                        // power of two, pointers wrap freely
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // Register indexes, one per 32-bit word.
  typedef enum logic [2:0] {
    REG_GAIN_DAY     = 3'd0,
    REG_GAIN_EVENING = 3'd1,
    REG_GAIN_NIGHT   = 3'd2,
    REG_DUTY_MAX     = 3'd3,
    REG_SET_MIN_MV   = 3'd4,
    REG_SET_MAX_MV   = 3'd5,
    REG_DEAD_BAND    = 3'd6
  } reg_idx_t;

  // Lighting period codes.
  typedef enum logic [PERIOD_W-1:0] {
    PERIOD_DAY     = 2'd0,
    PERIOD_EVENING = 2'd1,
    PERIOD_NIGHT   = 2'd2,
    PERIOD_NONE    = 2'd3
  } period_t;

  // Direction decided by the front for one sample.
  typedef enum logic [1:0] {
    STEP_HOLD = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_t;

  typedef struct packed {
    logic [MV_W-1:0]     set_mv;
    logic [MV_W-1:0]     feedback_mv;
    logic [PERIOD_W-1:0] period;
    logic                analog_valid;
  } sample_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [DUTY_W-1:0] duty_average;
  } result_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_day;
    logic [GAIN_W-1:0] gain_evening;
    logic [GAIN_W-1:0] gain_night;
    logic [DUTY_W-1:0] duty_max;
    logic [MV_W-1:0]   set_min_mv;
    logic [MV_W-1:0]   set_max_mv;
    logic [DB_W-1:0]   dead_band;
  } ldr_cfg_t;

  // One classified sample waiting for the back end.
  typedef struct packed {
    step_t step;
    logic  force_zero;
    logic  force_max;
  } step_entry_t;

endpackage

`default_nettype wire

// ----- rtl/ldr_cfg.sv -----
// APB-style configuration register file of the lamp current duty regulator.
`default_nettype none

module ldr_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [ldr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ldr_pkg::DATA_W-1:0] pwdata,
  output logic      [ldr_pkg::DATA_W-1:0] prdata,
  output logic                           pready,
  output ldr_pkg::ldr_cfg_t              cfg
);
  import ldr_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  // Register writes; unknown word addresses are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_day     <= GAIN_W'(1000);
      cfg.gain_evening <= GAIN_W'(1000);
      cfg.gain_night   <= GAIN_W'(1000);
      cfg.duty_max     <= '1;
      cfg.set_min_mv   <= '0;
      cfg.set_max_mv   <= '1;
      cfg.dead_band    <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_GAIN_DAY:     cfg.gain_day     <= pwdata[GAIN_W-1:0];
        REG_GAIN_EVENING: cfg.gain_evening <= pwdata[GAIN_W-1:0];
        REG_GAIN_NIGHT:   cfg.gain_night   <= pwdata[GAIN_W-1:0];
        REG_DUTY_MAX:     cfg.duty_max     <= pwdata[DUTY_W-1:0];
        REG_SET_MIN_MV:   cfg.set_min_mv   <= pwdata[MV_W-1:0];
        REG_SET_MAX_MV:   cfg.set_max_mv   <= pwdata[MV_W-1:0];
        REG_DEAD_BAND:    cfg.dead_band    <= pwdata[DB_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux, zero extended.
  always_comb begin
    case (idx)
      REG_GAIN_DAY:     prdata = DATA_W'(cfg.gain_day);
      REG_GAIN_EVENING: prdata = DATA_W'(cfg.gain_evening);
      REG_GAIN_NIGHT:   prdata = DATA_W'(cfg.gain_night);
      REG_DUTY_MAX:     prdata = DATA_W'(cfg.duty_max);
      REG_SET_MIN_MV:   prdata = DATA_W'(cfg.set_min_mv);
      REG_SET_MAX_MV:   prdata = DATA_W'(cfg.set_max_mv);
      REG_DEAD_BAND:    prdata = DATA_W'(cfg.dead_band);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/ldr_front.sv -----
// Front pipeline: accepts samples, computes target and measured current and classifies the step.
`default_nettype none

module ldr_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ldr_pkg::ldr_cfg_t    cfg,
  input  wire logic                 sample_valid,
  output logic                      sample_ready,
  input  wire ldr_pkg::sample_t     sample,
  input  wire logic                 q_full,
  output logic                      push,
  output ldr_pkg::step_entry_t      push_entry
);
  import ldr_pkg::*;

  // Stage valid bits.
  logic a_valid, b_valid, c_valid, d_valid;
  logic en;

  // Stage A: raw products and forcing flags.
  logic [PROD_W-1:0]   a_prod;
  logic [MNUM_W-1:0]   a_mnum;
  logic                a_fz, a_fm;
  // Stage B: reciprocal estimates.
  logic [TGT_W-1:0]    b_tq;
  logic [TY_W-1:0]     b_ty;
  logic [MEAS_W-1:0]   b_mq;
  logic [MNUM_W-1:0]   b_mnum;
  logic                b_fz, b_fm;
  // Stage C: corrected currents.
  logic [TGT_W-1:0]    c_target;
  logic [MEAS_W-1:0]   c_meas;
  logic                c_fz, c_fm;
  // Stage D: classified entry.
  step_entry_t         d_entry;

  // Combinational helpers.
  logic [GAIN_W-1:0]          gain;
  logic [MV_W-1:0]            fb_over;
  logic [TY_W+T_MUL_W-1:0]    t_full;
  logic [MNUM_W+M_MUL_W-1:0]  m_full;
  logic [T_REM_W-1:0]         t_rem;
  logic [MNUM_W-1:0]          m_rem;
  logic [TGT_W:0]             meas_db;
  logic [TGT_W:0]             tgt_db;
  step_t                      step;

  // The whole pipeline advances unless the last stage is stuck behind a full queue.
  assign en           = !(d_valid && q_full);
  assign sample_ready = en;
  assign push         = d_valid && !q_full;
  assign push_entry   = d_entry;

  // Stage A inputs: gain of the period and feedback above the sense offset.
  always_comb begin
    case (period_t'(sample.period))
      PERIOD_DAY:     gain = cfg.gain_day;
      PERIOD_EVENING: gain = cfg.gain_evening;
      PERIOD_NIGHT:   gain = cfg.gain_night;
      default:        gain = '0;
    endcase
    fb_over = (sample.feedback_mv >= MV_W'(FB_OFFSET)) ?
              sample.feedback_mv - MV_W'(FB_OFFSET) : '0;
  end

  // Stage B inputs: reciprocal multiplies for the constant divisions.
  assign t_full = TY_W'(a_prod >> 3) * T_MUL_W'(T_MUL);
  assign m_full = a_mnum * M_MUL_W'(M_MUL);

  // Stage C inputs: remainders that tell whether the estimate is one short.
  assign t_rem = {1'b0, b_ty} - T_REM_W'(b_tq * T_REM_W'(125));
  assign m_rem = b_mnum - MNUM_W'(b_mq * MNUM_W'(3));

  // Stage D inputs: compare with the dead band on either side.
  assign meas_db = (TGT_W+1)'(c_meas) + (TGT_W+1)'(cfg.dead_band);
  assign tgt_db  = (TGT_W+1)'(c_target) + (TGT_W+1)'(cfg.dead_band);
  always_comb begin
    if ((TGT_W+1)'(c_target) > meas_db) begin
      step = STEP_UP;
    end else if (tgt_db < (TGT_W+1)'(c_meas)) begin
      step = STEP_DOWN;
    end else begin
      step = STEP_HOLD;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else if (en) begin
      a_valid <= sample_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (en) begin
      a_prod   <= PROD_W'(sample.set_mv) * PROD_W'(gain);
      a_mnum   <= MNUM_W'(fb_over) * MNUM_W'(50);
      a_fz     <= sample.analog_valid && (sample.set_mv <= cfg.set_min_mv);
      a_fm     <= sample.analog_valid && (sample.set_mv >= cfg.set_max_mv);

      b_tq     <= t_full[T_SHIFT +: TGT_W];
      b_ty     <= TY_W'(a_prod >> 3);
      b_mq     <= m_full[M_SHIFT +: MEAS_W];
      b_mnum   <= a_mnum;
      b_fz     <= a_fz;
      b_fm     <= a_fm;

      c_target <= b_tq + TGT_W'(t_rem >= T_REM_W'(125));
      c_meas   <= b_mq + MEAS_W'(m_rem >= MNUM_W'(3));
      c_fz     <= b_fz;
      c_fm     <= b_fm;

      d_entry.step       <= step;
      d_entry.force_zero <= c_fz;
      d_entry.force_max  <= c_fm;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ldr_queue.sv -----
// Short FIFO of classified samples between the front pipeline and the duty back end.
`default_nettype none

module ldr_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire ldr_pkg::step_entry_t push_entry,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      empty,
  output ldr_pkg::step_entry_t      pop_entry
);
  import ldr_pkg::*;

  step_entry_t       slots [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(Q_DEPTH));
  assign empty     = (count == '0);
  assign pop_entry = slots[rd_ptr];

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ldr_back.sv -----
// Back end: steps the stored duty, keeps the block average and holds the result register.
`default_nettype none

module ldr_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ldr_pkg::ldr_cfg_t    cfg,
  input  wire logic                 q_empty,
  input  wire ldr_pkg::step_entry_t entry,
  output logic                      pop,
  output logic                      result_valid,
  input  wire logic                 result_ready,
  output ldr_pkg::result_t          result
);
  import ldr_pkg::*;

  // Regulator state.
  logic [DUTY_W-1:0] duty_reg;
  logic [SUM_W-1:0]  avg_sum;
  logic [CNT_W-1:0]  avg_count;
  logic [DUTY_W-1:0] avg_value;

  // Stage between the duty update and the result register.
  logic              b1_valid;
  logic [DUTY_W-1:0] b1_duty;
  logic              b1_done;
  logic [SUM_W-1:0]  b1_sum;

  logic              out_load;
  logic              b1_free;
  logic [DUTY_W-1:0] duty_next;
  logic [SUM_W-1:0]  sum_next;
  logic [CNT_W:0]    n;
  logic              block_done;
  logic [SUM_W+AVG_MUL_W-1:0] avg_full;
  logic [DUTY_W-1:0] avg_next;

  assign out_load = b1_valid && (!result_valid || result_ready);
  assign b1_free  = !b1_valid || out_load;
  assign pop      = !q_empty && b1_free;

  // One duty step, then the forcing rules; forcing to maximum wins.
  always_comb begin
    duty_next = duty_reg;
    case (entry.step)
      STEP_UP: begin
        duty_next = (duty_reg < cfg.duty_max) ? duty_reg + 1'b1 : cfg.duty_max;
      end
      STEP_DOWN: begin
        duty_next = (duty_reg != '0) ? duty_reg - 1'b1 : duty_reg;
      end
      default: ;
    endcase
    if (entry.force_zero) begin
      duty_next = '0;
    end
    if (entry.force_max) begin
      duty_next = cfg.duty_max;
    end
  end

  // Running block sum.
  assign sum_next   = avg_sum + SUM_W'(duty_next);
  assign n          = (CNT_W+1)'(avg_count) + 1'b1;
  assign block_done = (n >= (CNT_W+1)'(AVG_LEN));

  // Exact floor mean of a finished block by reciprocal multiply.
  assign avg_full = b1_sum * AVG_MUL_W'(AVG_MUL);
  assign avg_next = b1_done ? avg_full[AVG_SHIFT +: DUTY_W] : avg_value;

  // Duty and averaging state, updated once per popped entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_reg  <= '0;
      avg_sum   <= '0;
      avg_count <= '0;
    end else if (pop) begin
      duty_reg <= duty_next;
      if (block_done) begin
        avg_sum   <= '0;
        avg_count <= '0;
      end else begin
        avg_sum   <= sum_next;
        avg_count <= n[CNT_W-1:0];
      end
    end
  end

  // Middle stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (b1_free) begin
      b1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_duty <= duty_next;
      b1_done <= block_done;
      b1_sum  <= sum_next;
    end
  end

  // Result register and latest average.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      avg_value    <= '0;
    end else begin
      if (out_load) begin
        result_valid <= 1'b1;
        avg_value    <= avg_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.duty         <= b1_duty;
      result.duty_average <= avg_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lamp_current_duty_regulator.sv -----
// Top level of the lamp current duty regulator.
`default_nettype none

// Each accepted sample beat yields exactly one result beat carrying the new PWM duty and
// the latest completed average over AVG_LEN duty values. The block takes one sample per
// clock for as long as the result side keeps taking results; the loop that limits this
// is the registered duty update in the back end. On its way to the result a sample passes
// four front stages that compute and classify the currents, then a two-entry queue and
// two back-end stages. Registers may only be written while no sample is in flight; the
// configuration port always answers with pready high.
module lamp_current_duty_regulator (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ldr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ldr_pkg::DATA_W-1:0] pwdata,
  output logic      [ldr_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  input  wire logic                       sample_valid,
  output logic                            sample_ready,
  input  wire ldr_pkg::sample_t           sample,
  output logic                            result_valid,
  input  wire logic                       result_ready,
  output ldr_pkg::result_t                result
);
  import ldr_pkg::*;

  ldr_cfg_t    cfg;
  logic        q_full, q_empty, push, pop;
  step_entry_t push_entry, pop_entry;

  // Configuration registers.
  ldr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Current computation and step classification.
  ldr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  // Decoupling queue.
  ldr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .pop_entry  (pop_entry)
  );

  // Duty stepping, averaging and result register.
  ldr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .entry        (pop_entry),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire
